/* hw/rtl/mvlq_pkg.sv */
// shared types and constants for the midi event vlq encoder
`default_nettype none
package mvlq_pkg;

    localparam int unsigned DELTA_W = 28;
    localparam int unsigned GROUP_W = 7;
    localparam logic [7:0] GROUP_MASK = 8'h7F;
    localparam logic [7:0] CONT_FLAG = 8'h80;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;
    localparam logic [2:0] EVENT_BYTES = 3'd3;

    // one classified event: payload plus number of delta groups minus one
    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [7:0]         status;
        logic [6:0]         data_one;
        logic [6:0]         data_two;
        logic [1:0]         groups_m1;
    } entry_t;

endpackage
`default_nettype wire

/* hw/rtl/midi_event_vlq_encoder.sv */
// top level of the midi channel event encoder with variable-length delta
//
// input channel (in_valid/in_ready): one midi channel event per transaction,
// with delta_time, event_type, channel, param_one and param_two.
// output channel (out_valid/out_ready): one encoded byte per transaction,
// delta first as big-endian 7-bit groups, then status and two data bytes;
// is_last marks the final byte of the event.
// each event yields 4 to 7 bytes; the back-end byte sequencer issues one byte
// per cycle while the receiver accepts, and takes the next event from the queue
// as it issues the last byte of the current one.
// the first byte passes through the front register, the two-entry queue, the
// back-end event register and the output register.
// the front end keeps accepting while the queue has room, so up to four
// events, the one being sequenced included, may be held while the receiver
// stalls; a stalled byte holds.
// reset empties the front register, queue and output register.
`default_nettype none
module midi_event_vlq_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [27:0] delta_time,
    input  wire logic [3:0]  event_type,
    input  wire logic [3:0]  channel,
    input  wire logic [7:0]  param_one,
    input  wire logic [7:0]  param_two,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             is_last
);

    logic             push_valid;
    logic             push_ready;
    mvlq_pkg::entry_t push_entry;
    logic             pop_valid;
    logic             pop_ready;
    mvlq_pkg::entry_t pop_entry;

    mvlq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .delta_time (delta_time),
        .event_type (event_type),
        .channel    (channel),
        .param_one  (param_one),
        .param_two  (param_two),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    mvlq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    mvlq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .is_last   (is_last)
    );

    // final byte is a data byte, never carries a continuation flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_last) |-> (out_byte[7] == 1'b0))
        else $error("last byte has bit 7 set");

    // a stalled byte from the sequencer holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(is_last)))
        else $error("output changed while stalled");

    // front end stalls whenever its held event cannot enter the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |-> !in_ready)
        else $error("front accepted while queue full");

endmodule
`default_nettype wire

/* hw/rtl/mvlq_front.sv */
// front end: accepts events, builds the status byte and sizes the delta
`default_nettype none
module mvlq_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [27:0]          delta_time,
    input  wire logic [3:0]           event_type,
    input  wire logic [3:0]           channel,
    input  wire logic [7:0]           param_one,
    input  wire logic [7:0]           param_two,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output mvlq_pkg::entry_t          push_entry
);

    logic             valid_reg;
    logic             valid_next;
    mvlq_pkg::entry_t entry_reg;
    mvlq_pkg::entry_t entry_next;
    logic [1:0]       groups_m1;

    always_comb
    begin
        priority if (delta_time[27:21] != 7'd0)
        begin
            groups_m1 = 2'd3;
        end
        else if (delta_time[20:14] != 7'd0)
        begin
            groups_m1 = 2'd2;
        end
        else if (delta_time[13:7] != 7'd0)
        begin
            groups_m1 = 2'd1;
        end
        else
        begin
            groups_m1 = 2'd0;
        end
    end

    assign in_ready = !valid_reg || push_ready;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (valid_reg && push_ready)
        begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            valid_next           = 1'b1;
            entry_next.delta     = delta_time;
            entry_next.status    = {event_type & mvlq_pkg::NIBBLE_MASK,
                                    channel & mvlq_pkg::NIBBLE_MASK};
            entry_next.data_one  = param_one[6:0];
            entry_next.data_two  = param_two[6:0];
            entry_next.groups_m1 = groups_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

endmodule
`default_nettype wire

/* hw/rtl/mvlq_queue.sv */
// two-entry queue between front and back end
`default_nettype none
module mvlq_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire mvlq_pkg::entry_t     push_entry,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output mvlq_pkg::entry_t          pop_entry
);

    mvlq_pkg::entry_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/mvlq_back.sv */
// back end: sequences the encoded bytes of one event into the output register
`default_nettype none
module mvlq_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire mvlq_pkg::entry_t     pop_entry,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                out_byte,
    output logic                      is_last
);

    logic             busy_reg;
    logic             busy_next;
    mvlq_pkg::entry_t cur_reg;
    mvlq_pkg::entry_t cur_next;
    logic [2:0]       idx_reg;
    logic [2:0]       idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic             is_last_reg;
    logic             is_last_next;

    logic             advance;
    logic             at_last;
    logic [2:0]       groups;
    logic [1:0]       group_sel;
    logic [6:0]       group_bits;
    logic [7:0]       cur_byte;

    assign groups  = {1'b0, cur_reg.groups_m1} + 3'd1;
    assign at_last = (idx_reg == ({1'b0, cur_reg.groups_m1} + mvlq_pkg::EVENT_BYTES));
    assign advance = busy_reg && (!out_valid_reg || out_ready);
    assign pop_ready = !busy_reg || (advance && at_last);

    // most significant group first
    assign group_sel = cur_reg.groups_m1 - idx_reg[1:0];

    always_comb
    begin
        unique case (group_sel)
            2'd0: group_bits = cur_reg.delta[6:0];
            2'd1: group_bits = cur_reg.delta[13:7];
            2'd2: group_bits = cur_reg.delta[20:14];
            2'd3: group_bits = cur_reg.delta[27:21];
        endcase
    end

    always_comb
    begin
        priority if (idx_reg < groups)
        begin
            cur_byte = ({1'b0, group_bits} & mvlq_pkg::GROUP_MASK)
                     | ((group_sel != 2'd0) ? mvlq_pkg::CONT_FLAG : 8'h00);
        end
        else if (idx_reg == groups)
        begin
            cur_byte = cur_reg.status;
        end
        else if (idx_reg == groups + 3'd1)
        begin
            cur_byte = {1'b0, cur_reg.data_one};
        end
        else
        begin
            cur_byte = {1'b0, cur_reg.data_two};
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        is_last_next   = is_last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            is_last_next   = at_last;
            idx_next       = idx_reg + 3'd1;
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop_valid && pop_ready)
        begin
            busy_next = 1'b1;
            cur_next  = pop_entry;
            idx_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        is_last_reg  <= is_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_last   = is_last_reg;

endmodule
`default_nettype wire
